/* sv/tdx_pkg.sv */
package tdx_pkg;

  localparam int CORDIC_STEPS_DEF = 20;
  localparam int FRAC_BITS_DEF    = 10;

  localparam logic [2:0] REG_X_START  = 3'd0;
  localparam logic [2:0] REG_X_CORNER = 3'd1;
  localparam logic [2:0] REG_X_END    = 3'd2;
  localparam logic [2:0] REG_Z_TOP    = 3'd3;
  localparam logic [2:0] REG_Z_BOTTOM = 3'd4;
  localparam logic [2:0] REG_Y_BASE   = 3'd5;
  localparam logic [2:0] REG_RADIUS   = 3'd6;

  localparam logic [2:0] SEG_LINE1 = 3'd0;
  localparam logic [2:0] SEG_ARC1  = 3'd1;
  localparam logic [2:0] SEG_LINE2 = 3'd2;
  localparam logic [2:0] SEG_ARC2  = 3'd3;
  localparam logic [2:0] SEG_LINE3 = 3'd4;

  localparam logic signed [31:0] X_START_RST  = -32'sd858317;
  localparam logic signed [31:0] X_CORNER_RST = 32'sd670413;
  localparam logic signed [31:0] X_END_RST    = 32'sd405709;
  localparam logic signed [31:0] Z_TOP_RST    = -32'sd91136;
  localparam logic signed [31:0] Z_BOTTOM_RST = -32'sd372838;
  localparam logic signed [31:0] Y_BASE_RST   = 32'sd425684;
  localparam logic [20:0]        RADIUS_RST   = 21'd51200;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] GAIN_Q30    = 32'd652032874;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

endpackage

/* sv/track_distance_to_xyz_core.sv */
// Rail carriage position to 3D point. Takes one word per cycle while not
// stalled. Each word passes segment search stages, a one-bit-per-stage
// divider for the arc angle, one stage per CORDIC iteration, then scale,
// merge and clamp stages. A stall on the result side freezes the whole
// pipeline. Register writes are not staged with the words: a word already
// in flight sees the new value at each later stage that reads the register.
module track_distance_to_xyz_core #(
  parameter int CORDIC_STEPS = tdx_pkg::CORDIC_STEPS_DEF,
  parameter int FRAC_BITS    = tdx_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [23:0]        in_travel_distance,
  input  logic [23:0]        in_vertical_drop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_pos_x,
  output logic signed [39:0] out_pos_y,
  output logic signed [31:0] out_pos_z,
  output logic [2:0]         out_segment,
  output logic               out_clamped
);

  localparam int DW = ((24 + FRAC_BITS > 38) ? 24 + FRAC_BITS : 38) + 1;
  localparam int SW = DW + 2;
  localparam int CW = 34;
  localparam int CS = CORDIC_STEPS;

  typedef struct packed {
    logic [2:0]           seg;
    logic                 clamped;
    logic                 tlsb;
    logic signed [39:0]   y;
    logic signed [SW-1:0] xl;
    logic signed [SW-1:0] zl;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [SW-1:0] v);
    logic [SW-32:0] up;
    up = v[SW-1:31];
    if ((&up) || !(|up)) return v[31:0];
    return v[SW-1] ? 32'h8000_0000 : 32'h7fff_ffff;
  endfunction

  function automatic logic signed [39:0] sat40(input logic signed [SW-1:0] v);
    logic [SW-40:0] up;
    up = v[SW-1:39];
    if ((&up) || !(|up)) return v[39:0];
    return v[SW-1] ? 40'h80_0000_0000 : 40'h7f_ffff_ffff;
  endfunction

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !rst_n || (out_valid && out_stall);

  // configuration
  logic signed [31:0] x_start_r, x_corner_r, x_end_r, z_top_r, z_bottom_r, y_base_r;
  logic [20:0]        radius_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_start_r  <= tdx_pkg::X_START_RST;
      x_corner_r <= tdx_pkg::X_CORNER_RST;
      x_end_r    <= tdx_pkg::X_END_RST;
      z_top_r    <= tdx_pkg::Z_TOP_RST;
      z_bottom_r <= tdx_pkg::Z_BOTTOM_RST;
      y_base_r   <= tdx_pkg::Y_BASE_RST;
      radius_r   <= tdx_pkg::RADIUS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tdx_pkg::REG_X_START:  x_start_r  <= cfg_wdata;
        tdx_pkg::REG_X_CORNER: x_corner_r <= cfg_wdata;
        tdx_pkg::REG_X_END:    x_end_r    <= cfg_wdata;
        tdx_pkg::REG_Z_TOP:    z_top_r    <= cfg_wdata;
        tdx_pkg::REG_Z_BOTTOM: z_bottom_r <= cfg_wdata;
        tdx_pkg::REG_Y_BASE:   y_base_r   <= cfg_wdata;
        tdx_pkg::REG_RADIUS:   radius_r   <= cfg_wdata[20:0];
        default: ;
      endcase
    end
  end

  // derived path geometry
  logic signed [34:0] r35, l1_raw, l2_raw, l3_raw, xcr_nxt;
  logic [52:0]        ca_prod;
  logic [21:0]        ca_r;
  logic [DW-1:0]      l1_r, l2_r, l3_r;
  logic signed [34:0] xcr_r, ztr_r, zbr_r;
  logic [DW-1:0]      b1_r, b2_r, b3_r, b4_r, tot_r;

  assign r35     = 35'(radius_r);
  assign xcr_nxt = 35'(x_corner_r) - r35;
  assign l1_raw  = 35'(x_corner_r) - 35'(x_start_r) - r35;
  assign l2_raw  = 35'(z_top_r) - 35'(z_bottom_r) - (r35 <<< 1);
  assign l3_raw  = xcr_nxt - 35'(x_end_r);
  assign ca_prod = 53'(radius_r) * 53'(tdx_pkg::HALF_PI_Q30) + 53'(1 << 29);

  always_ff @(posedge clk) begin
    ca_r  <= ca_prod[51:30];
    l1_r  <= l1_raw[34] ? '0 : DW'(l1_raw[33:0]);
    l2_r  <= l2_raw[34] ? '0 : DW'(l2_raw[33:0]);
    l3_r  <= l3_raw[34] ? '0 : DW'(l3_raw[33:0]);
    xcr_r <= xcr_nxt;
    ztr_r <= 35'(z_top_r) - r35;
    zbr_r <= 35'(z_bottom_r) + r35;
    b1_r  <= l1_r;
    b2_r  <= l1_r + DW'(ca_r);
    b3_r  <= l1_r + DW'(ca_r) + l2_r;
    b4_r  <= l1_r + DW'({ca_r, 1'b0}) + l2_r;
    tot_r <= l1_r + DW'({ca_r, 1'b0}) + l2_r + l3_r;
  end

  // segment search
  logic          s0_v_r, s1_v_r, s2_v_r, s3_v_r;
  logic [23:0]   s0_trav_r, s0_drop_r;
  logic [DW-1:0] s1_d_r, s2_d_r, s2_base_r, s3_t_r;
  logic          s1_zero_r, s2_zero_r, s3_zero_r;
  logic signed [39:0] s1_y_r, s2_y_r, s3_y_r;
  logic [2:0]    s2_seg_r, s3_seg_r;
  logic          s2_clamp_r, s3_clamp_r;
  logic [DW-1:0] s3_d_r;
  logic [2:0]    seg_nxt;
  logic [DW-1:0] base_nxt;
  side_t         side_nxt;

  always_comb begin
    if (s1_d_r < b1_r) begin
      seg_nxt = tdx_pkg::SEG_LINE1; base_nxt = '0;
    end else if (s1_d_r < b2_r) begin
      seg_nxt = tdx_pkg::SEG_ARC1;  base_nxt = b1_r;
    end else if (s1_d_r < b3_r) begin
      seg_nxt = tdx_pkg::SEG_LINE2; base_nxt = b2_r;
    end else if (s1_d_r < b4_r) begin
      seg_nxt = tdx_pkg::SEG_ARC2;  base_nxt = b3_r;
    end else begin
      seg_nxt = tdx_pkg::SEG_LINE3; base_nxt = b4_r;
    end
    if (s1_zero_r) begin
      seg_nxt = tdx_pkg::SEG_LINE1; base_nxt = '0;
    end
  end

  always_comb begin
    side_nxt.seg     = s3_seg_r;
    side_nxt.clamped = s3_clamp_r;
    side_nxt.tlsb    = s3_t_r[0];
    side_nxt.y       = s3_y_r;
    side_nxt.xl      = '0;
    side_nxt.zl      = '0;
    if (s3_zero_r) begin
      side_nxt.xl = SW'(x_start_r);
      side_nxt.zl = SW'(z_top_r);
    end else if (s3_clamp_r) begin
      side_nxt.xl = SW'(x_end_r);
      side_nxt.zl = SW'(z_bottom_r);
    end else begin
      case (s3_seg_r)
        tdx_pkg::SEG_LINE1: begin
          side_nxt.xl = SW'(x_start_r) + $signed(SW'(s3_d_r));
          side_nxt.zl = SW'(z_top_r);
        end
        tdx_pkg::SEG_LINE2: begin
          side_nxt.xl = SW'(x_corner_r);
          side_nxt.zl = SW'(ztr_r) - $signed(SW'(s3_t_r));
        end
        tdx_pkg::SEG_LINE3: begin
          side_nxt.xl = SW'(xcr_r) - $signed(SW'(s3_t_r));
          side_nxt.zl = SW'(z_bottom_r);
        end
        default: ;
      endcase
    end
  end

  logic               dv_v  [0:31];
  side_t              dv_s  [0:31];
  logic [20:0]        dv_rem[0:31];
  logic [30:0]        dv_q  [0:31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      dv_v[0] <= 1'b0;
    end else if (en) begin
      s0_v_r  <= in_valid;
      s1_v_r  <= s0_v_r;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      dv_v[0] <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_trav_r  <= in_travel_distance;
      s0_drop_r  <= in_vertical_drop;
      s1_d_r     <= DW'(s0_trav_r) << FRAC_BITS;
      s1_zero_r  <= (s0_trav_r == '0);
      s1_y_r     <= sat40(SW'(y_base_r) - $signed(SW'(DW'(s0_drop_r) << FRAC_BITS)));
      s2_d_r     <= s1_d_r;
      s2_zero_r  <= s1_zero_r;
      s2_y_r     <= s1_y_r;
      s2_clamp_r <= !s1_zero_r && (s1_d_r >= tot_r);
      s2_seg_r   <= (!s1_zero_r && (s1_d_r >= tot_r)) ? tdx_pkg::SEG_LINE3 : seg_nxt;
      s2_base_r  <= base_nxt;
      s3_t_r     <= s2_d_r - s2_base_r;
      s3_d_r     <= s2_d_r;
      s3_zero_r  <= s2_zero_r;
      s3_y_r     <= s2_y_r;
      s3_seg_r   <= s2_seg_r;
      s3_clamp_r <= s2_clamp_r;
      dv_s[0]    <= side_nxt;
      dv_rem[0]  <= s3_t_r[21:1];
      dv_q[0]    <= '0;
    end
  end

  // angle = t * 2^30 / r, one quotient bit per stage
  for (genvar k = 0; k < 31; k++) begin : g_div
    logic [21:0] cand;
    logic        ge;
    logic [21:0] diff;
    assign cand = {dv_rem[k], (k == 0) ? dv_s[k].tlsb : 1'b0};
    assign ge   = cand >= {1'b0, radius_r};
    assign diff = cand - {1'b0, radius_r};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v[k+1] <= 1'b0;
      end else if (en) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_s[k+1]   <= dv_s[k];
        dv_rem[k+1] <= ge ? diff[20:0] : cand[20:0];
        dv_q[k+1]   <= dv_q[k] | ({30'd0, ge} << (30 - k));
      end
    end
  end

  // CORDIC rotation, one iteration per stage
  logic                 cd_v[0:CS];
  side_t                cd_s[0:CS];
  logic signed [CW-1:0] cd_x[0:CS];
  logic signed [CW-1:0] cd_y[0:CS];
  logic signed [CW-1:0] cd_z[0:CS];

  assign cd_v[0] = dv_v[31];
  assign cd_s[0] = dv_s[31];
  assign cd_x[0] = CW'(tdx_pkg::GAIN_Q30);
  assign cd_y[0] = '0;
  assign cd_z[0] = CW'(dv_q[31]);

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    logic signed [CW-1:0] at;
    assign at = CW'(tdx_pkg::ATAN_Q30[i]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cd_v[i+1] <= 1'b0;
      end else if (en) begin
        cd_v[i+1] <= cd_v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cd_s[i+1] <= cd_s[i];
        if (!cd_z[i][CW-1]) begin
          cd_x[i+1] <= cd_x[i] - (cd_y[i] >>> i);
          cd_y[i+1] <= cd_y[i] + (cd_x[i] >>> i);
          cd_z[i+1] <= cd_z[i] - at;
        end else begin
          cd_x[i+1] <= cd_x[i] + (cd_y[i] >>> i);
          cd_y[i+1] <= cd_y[i] - (cd_x[i] >>> i);
          cd_z[i+1] <= cd_z[i] + at;
        end
      end
    end
  end

  // scale, merge, clamp
  logic               m_v_r, f_v_r, out_v_r;
  side_t              m_s_r;
  logic signed [55:0] m_rs_r, m_rc_r;
  logic signed [55:0] rs_sum, rc_sum;
  logic signed [SW-1:0] rs_w, rc_w, fx_nxt, fz_nxt;
  logic signed [SW-1:0] f_x_r, f_z_r;
  logic [2:0]         f_seg_r;
  logic               f_clamp_r;
  logic signed [39:0] f_y_r;
  logic signed [31:0] o_x_r, o_z_r;
  logic signed [39:0] o_y_r;
  logic [2:0]         o_seg_r;
  logic               o_clamp_r;
  logic signed [21:0] r22;

  assign r22    = $signed({1'b0, radius_r});
  assign rs_sum = m_rs_r + 56'sd536870912;
  assign rc_sum = m_rc_r + 56'sd536870912;
  assign rs_w   = SW'($signed(rs_sum[55:30]));
  assign rc_w   = SW'($signed(rc_sum[55:30]));

  always_comb begin
    fx_nxt = m_s_r.xl;
    fz_nxt = m_s_r.zl;
    if (!m_s_r.clamped) begin
      case (m_s_r.seg)
        tdx_pkg::SEG_ARC1: begin
          fx_nxt = SW'(xcr_r) + rs_w;
          fz_nxt = SW'(ztr_r) + rc_w;
        end
        tdx_pkg::SEG_ARC2: begin
          fx_nxt = SW'(xcr_r) + rc_w;
          fz_nxt = SW'(zbr_r) - rs_w;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r   <= 1'b0;
      f_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else if (en) begin
      m_v_r   <= cd_v[CS];
      f_v_r   <= m_v_r;
      out_v_r <= f_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_s_r     <= cd_s[CS];
      m_rs_r    <= r22 * cd_y[CS];
      m_rc_r    <= r22 * cd_x[CS];
      f_x_r     <= fx_nxt;
      f_z_r     <= fz_nxt;
      f_y_r     <= m_s_r.y;
      f_seg_r   <= m_s_r.seg;
      f_clamp_r <= m_s_r.clamped;
      o_x_r     <= sat32(f_x_r);
      o_z_r     <= sat32(f_z_r);
      o_y_r     <= f_y_r;
      o_seg_r   <= f_seg_r;
      o_clamp_r <= f_clamp_r;
    end
  end

  assign out_valid   = out_v_r;
  assign out_pos_x   = o_x_r;
  assign out_pos_y   = o_y_r;
  assign out_pos_z   = o_z_r;
  assign out_segment = o_seg_r;
  assign out_clamped = o_clamp_r;

endmodule

/* sv/tdx_checker.sv */
module tdx_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_pos_x,
  input logic [2:0]         out_segment,
  input logic               out_clamped
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pos_x) && $stable(out_segment))
    else $error("result word changed while stalled");

  a_seg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_segment <= tdx_pkg::SEG_LINE3)
    else $error("segment code out of range");

  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clamped |-> out_segment == tdx_pkg::SEG_LINE3)
    else $error("clamped word not on last run");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !out_valid |-> !in_stall)
    else $error("input held with empty output");

endmodule

bind track_distance_to_xyz_core tdx_checker u_tdx_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_pos_x   (out_pos_x),
  .out_segment (out_segment),
  .out_clamped (out_clamped)
);
